/* hw/rtl/tdohds_pkg.sv */
// Package for the three-digit one-hot display shifter.
// Holds constants, the handshake struct between the front end and the serializer,
// and the digit encoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdohds_pkg;

  localparam int unsigned ValueWidth = 16;
  localparam int unsigned WordBits   = 32;
  localparam int unsigned PosWidth   = 5;

  localparam logic [ValueWidth-1:0] ShownReset = 16'd1000;
  localparam logic [ValueWidth-1:0] ClampLimit = 16'd1000;
  localparam logic [9:0]            ClampMax   = 10'd999;
  localparam logic [PosWidth-1:0]   SpareBit   = 5'd31;
  localparam logic [PosWidth-1:0]   TensBase   = 5'd10;
  localparam logic [PosWidth-1:0]   UnitsBase  = 5'd20;
  localparam logic [PosWidth-1:0]   FirstPos   = 5'd31;
  localparam logic [PosWidth-1:0]   LastPos    = 5'd0;

  typedef struct packed {
    logic                valid;
    logic [WordBits-1:0] word;
  } word_item_t;

  // Digits by reciprocal multiply: v*41>>12 is v/100 for v < 1000,
  // r*205>>11 is r/10 for r < 100.
  function automatic logic [WordBits-1:0] encode_word(input logic [9:0] v);
    logic [15:0]         h_prod;
    logic [3:0]          hund;
    logic [9:0]          rem_full;
    logic [6:0]          rem;
    logic [14:0]         t_prod;
    logic [3:0]          tens;
    logic [6:0]          units_full;
    logic [3:0]          units;
    logic [WordBits-1:0] w;
    h_prod     = {6'd0, v} * 16'd41;
    hund       = h_prod[15:12];
    rem_full   = v - ({6'd0, hund} * 10'd100);
    rem        = rem_full[6:0];
    t_prod     = {8'd0, rem} * 15'd205;
    tens       = t_prod[14:11];
    units_full = rem - ({3'd0, tens} * 7'd10);
    units      = units_full[3:0];
    w          = '0;
    if (v >= 10'd100) begin
      w[{1'b0, hund}] = 1'b1;
    end else begin
      w[SpareBit] = 1'b1;
    end
    if (v >= 10'd10) begin
      w[{1'b0, tens} + TensBase] = 1'b1;
    end else begin
      w[SpareBit] = 1'b1;
    end
    w[{1'b0, units} + UnitsBase] = 1'b1;
    return w;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tdohds_front.sv */
// Front end: input register, unchanged-value filter and digit encoding.
// Depends on tdohds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdohds_front
  import tdohds_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [ValueWidth-1:0] value_i,
  output word_item_t                 word_o,
  input  wire logic                  word_ready_i
);

  logic                  in_valid_q, in_valid_d;
  logic [ValueWidth-1:0] value_q, value_d;
  logic [ValueWidth-1:0] shown_q, shown_d;
  logic                  same;
  logic                  consume;
  logic [9:0]            clamped;

  assign same    = (value_q == shown_q);
  assign consume = in_valid_q && (same || word_ready_i);
  assign clamped = (value_q < ClampLimit) ? value_q[9:0] : ClampMax;

  assign in_ready_o   = !in_valid_q || consume;
  assign word_o.valid = in_valid_q && !same;
  assign word_o.word  = encode_word(clamped);

  always_comb begin
    in_valid_d = in_valid_q;
    value_d    = value_q;
    shown_d    = shown_q;
    if (consume) begin
      in_valid_d = 1'b0;
      if (!same) begin
        shown_d = value_q;
      end
    end
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
      value_d    = value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      shown_q    <= ShownReset;
    end else begin
      in_valid_q <= in_valid_d;
      shown_q    <= shown_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/tdohds_serializer.sv */
// Serializer: 32-bit shift register sent MSB first, with a result register.
// Depends on tdohds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdohds_serializer
  import tdohds_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  word_item_t               word_i,
  output logic                     word_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     serial_data_o,
  output logic [PosWidth-1:0]      bit_number_o
);

  logic                busy_q, busy_d;
  logic [WordBits-1:0] word_q, word_d;
  logic [PosWidth-1:0] pos_q, pos_d;
  logic                out_valid_q, out_valid_d;
  logic                data_q, data_d;
  logic [PosWidth-1:0] num_q, num_d;
  logic                out_free;
  logic                emit;

  assign out_free     = !out_valid_q || out_ready_i;
  assign emit         = busy_q && out_free;
  assign word_ready_o = !busy_q || (emit && (pos_q == LastPos));

  assign out_valid_o   = out_valid_q;
  assign serial_data_o = data_q;
  assign bit_number_o  = num_q;

  always_comb begin
    busy_d      = busy_q;
    word_d      = word_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    data_d      = data_q;
    num_d       = num_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      data_d      = ~word_q[WordBits-1];
      num_d       = pos_q;
      word_d      = {word_q[WordBits-2:0], 1'b0};
      pos_d       = pos_q - 5'd1;
      if (pos_q == LastPos) begin
        busy_d = 1'b0;
      end
    end
    if (word_i.valid && word_ready_o) begin
      busy_d = 1'b1;
      word_d = word_i.word;
      pos_d  = FirstPos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    pos_q  <= pos_d;
    data_q <= data_d;
    num_q  <= num_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/three_digit_one_hot_display_shifter.sv */
// Three-digit one-hot display shifter, top level.
// Depends on tdohds_pkg, tdohds_front and tdohds_serializer.
//
// Input channel: in_valid_i / in_ready_o carry a 16-bit value item.
// An item equal to the last value shown is dropped with no result.
// Otherwise the value is clamped to 999, split into three digits with
// leading zeros blanked, and encoded into a 32-bit one-hot word
// (hundreds bits 0-9, tens 10-19, units 20-29, blank marker bit 31).
// Output channel: out_valid_o / out_ready_i carry one result per word
// bit, MSB first: serial_data_o is the inverted bit, bit_number_o its
// position (31 down to 0), last_o marks bit 0, after which the latch
// pulse is due.
// The first result of an item goes through the input, shift and result
// registers. A changed value is shifted out of the single shift register,
// one result per word bit; an unchanged value is consumed without waiting
// for the serializer. The next item enters the input register while a
// word is shifted. Reset clears all valid flags and sets the shown value
// to 1000. A stalled receiver holds the result and shift registers.
`timescale 1ns / 1ps
`default_nettype none

module three_digit_one_hot_display_shifter
  import tdohds_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [ValueWidth-1:0] value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       serial_data_o,
  output logic [PosWidth-1:0]        bit_number_o,
  output logic                       last_o
);

  word_item_t word;
  logic       word_ready;

  tdohds_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .word_o      (word),
    .word_ready_i(word_ready)
  );

  tdohds_serializer u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_i       (word),
    .word_ready_o (word_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .serial_data_o(serial_data_o),
    .bit_number_o (bit_number_o)
  );

  assign last_o = (bit_number_o == LastPos);

endmodule

`default_nettype wire
